FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clock, off during reset
`define RBED_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("rbed assertion failed");

// implication form
`define RBED_ASSERT_IMP(name, ante, cons) \
   `RBED_ASSERT(name, (ante) |-> (cons))

`endif

FILE: src/rbed_pkg.sv
// ----------------------------------------------------------------------------
// rbed_pkg
// widths, constants and types of the ray versus box entry distance pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rbed_pkg;

   localparam int NUM_AXES    = 3;
   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int MAG_W       = COORD_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int MUL_W       = 2 * DIFF_W;
   localparam int GUARD_W     = 62 - COORD_W;
   localparam int ROOT_W      = (SUM_W + 2 * GUARD_W) / 2;
   localparam int ROOT_LO_W   = 32;
   localparam int ROOT_HI_W   = ROOT_W - ROOT_LO_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int PROD_W      = MAG_W + ROOT_W;
   localparam int DIST_W      = 31;
   localparam int QUO_W       = DIST_W;
   localparam int HEAD_W      = PROD_W - GUARD_W - QUO_W;
   localparam int DIV_STAGES  = QUO_W + 1;
   localparam int VAL_W       = QUO_W + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic zero_box;
      logic in_box;
   } flag_type;

   typedef struct packed {
      flag_type                            flags;
      logic [NUM_AXES-1:0]                 ok;
      logic [NUM_AXES-1:0][MAG_W-1:0]      num;
      logic [NUM_AXES-1:0][MAG_W-1:0]      den;
   } side_type;

   typedef struct packed {
      logic              ok;
      logic              sat;
      logic [MAG_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
      logic [QUO_W-1:0]  pend;
      logic [MAG_W-1:0]  den;
   } div_lane_type;

   typedef struct packed {
      logic              ok;
      logic              sat;
      logic [QUO_W-1:0]  quo;
   } lane_res_type;

   // saturated lanes sort above every exact quotient
   function automatic logic [VAL_W-1:0] lane_val(lane_res_type r);
      lane_val = r.sat ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r.quo};
   endfunction

endpackage

`default_nettype wire

FILE: src/rbed_sqrt.sv
// ----------------------------------------------------------------------------
// rbed_sqrt
// pipelined integer square root of the squared length with guard bits,
// one root bit per stage, request sideband carried alongside
// ----------------------------------------------------------------------------
`default_nettype none

module rbed_sqrt import rbed_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [SUM_W-1:0]   in_sum,
   input  wire side_type           in_side,
   output logic                    out_valid,
   output logic [ROOT_W-1:0]       out_root,
   output side_type                out_side
);

   logic              vld_ff  [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [SUM_W-1:0]  sum_ff  [SQRT_STAGES];
   side_type          side_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam int I = SQRT_STAGES - 1 - k;
      logic              vld_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SUM_W-1:0]  sum_prev;
      side_type          side_prev;
      logic [1:0]        pair;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign sum_prev  = in_sum;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign sum_prev  = sum_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // the guard shift leaves only zero pairs below the sum
      if (I >= GUARD_W) begin : g_pair
         assign pair = sum_prev[2*(I-GUARD_W) +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign cur   = {rem_prev, pair};
      assign trial = {2'b00, root_prev, 2'b01};

      always_comb begin
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[REM_W-1:0];
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            sum_ff[k]  <= sum_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: src/rbed_div.sv
// ----------------------------------------------------------------------------
// rbed_div
// three pipelined restoring dividers with an overflow check against the distance
// range in the first stage, then one quotient bit in each later stage
// ----------------------------------------------------------------------------
`default_nettype none

module rbed_div import rbed_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic [NUM_AXES-1:0][PROD_W-1:0] in_prod,
   input  wire logic [NUM_AXES-1:0][MAG_W-1:0]  in_den,
   input  wire logic [NUM_AXES-1:0]             in_ok,
   input  wire flag_type                        in_flags,
   output logic                                 out_valid,
   output lane_res_type [NUM_AXES-1:0]          out_res,
   output flag_type                             out_flags
);

   logic          vld_ff  [DIV_STAGES];
   flag_type      flag_ff [DIV_STAGES];
   div_lane_type  lane_ff [DIV_STAGES][NUM_AXES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic          vld_prev;
      flag_type      flag_prev;
      div_lane_type  lane_in [NUM_AXES];

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign flag_prev = in_flags;

         always_comb begin
            logic [HEAD_W-1:0] head;
            for (int a = 0; a < NUM_AXES; a++) begin
               head            = in_prod[a][PROD_W-1 -: HEAD_W];
               lane_in[a].ok   = in_ok[a];
               lane_in[a].den  = in_den[a];
               // quotient reaches 2^31 when the top part already covers den
               lane_in[a].sat  = head >= HEAD_W'(in_den[a]);
               lane_in[a].rem  = head[MAG_W-1:0];
               lane_in[a].quo  = '0;
               lane_in[a].pend = in_prod[a][GUARD_W +: QUO_W];
            end
         end
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign flag_prev = flag_ff[k-1];

         always_comb begin
            logic [MAG_W:0] cur;
            logic           ge;
            for (int a = 0; a < NUM_AXES; a++) begin
               lane_in[a] = lane_ff[k-1][a];
               cur = {lane_ff[k-1][a].rem, lane_ff[k-1][a].pend[QUO_W-1]};
               ge  = cur >= {1'b0, lane_ff[k-1][a].den};
               if (ge) begin
                  lane_in[a].rem = MAG_W'(cur - {1'b0, lane_ff[k-1][a].den});
               end else begin
                  lane_in[a].rem = cur[MAG_W-1:0];
               end
               lane_in[a].quo  = {lane_ff[k-1][a].quo[QUO_W-2:0], ge};
               lane_in[a].pend = {lane_ff[k-1][a].pend[QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            flag_ff[k] <= flag_prev;
            for (int a = 0; a < NUM_AXES; a++) begin
               lane_ff[k][a] <= lane_in[a];
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         out_res[a].ok  = lane_ff[DIV_STAGES-1][a].ok;
         out_res[a].sat = lane_ff[DIV_STAGES-1][a].sat;
         out_res[a].quo = lane_ff[DIV_STAGES-1][a].quo;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_flags = flag_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: src/ray_box_entry_distance_top.sv
// throughput: one request per cycle unless stalled; all stages move together
// the depth is set by the 63 stage square root and the 32 stage dividers
// a stalled result holds every stage; nothing is dropped or repeated
// reset: synchronous, active high, clears all valid bits; data is not reset
// ----------------------------------------------------------------------------
// ray_box_entry_distance_top
// ray segment versus axis-aligned box, distance to the entry point
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ray_box_entry_distance_top import rbed_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [31:0]  req_start_x,
   input  wire logic signed [31:0]  req_start_y,
   input  wire logic signed [31:0]  req_start_z,
   input  wire logic signed [31:0]  req_end_x,
   input  wire logic signed [31:0]  req_end_y,
   input  wire logic signed [31:0]  req_end_z,
   input  wire logic signed [31:0]  req_box_min_x,
   input  wire logic signed [31:0]  req_box_min_y,
   input  wire logic signed [31:0]  req_box_min_z,
   input  wire logic signed [31:0]  req_box_max_x,
   input  wire logic signed [31:0]  req_box_max_y,
   input  wire logic signed [31:0]  req_box_max_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit,
   output logic                     rsp_start_inside,
   output logic [DIST_W-1:0]        rsp_entry_distance,
   output logic                     rsp_saturated
);

   logic adv;

   // stage 1: differences and the early flags
   logic signed [COORD_W-1:0] st_c [NUM_AXES];
   logic signed [COORD_W-1:0] en_c [NUM_AXES];
   logic signed [COORD_W-1:0] lo_c [NUM_AXES];
   logic signed [COORD_W-1:0] hi_c [NUM_AXES];
   logic signed [DIFF_W-1:0]  s1_dif_in [NUM_AXES];
   logic signed [DIFF_W-1:0]  s1_lod_in [NUM_AXES];
   logic signed [DIFF_W-1:0]  s1_hid_in [NUM_AXES];
   flag_type                  s1_flags_in;

   logic                      s1_vld_ff;
   logic signed [DIFF_W-1:0]  s1_dif_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]  s1_lod_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]  s1_hid_ff [NUM_AXES];
   flag_type                  s1_flags_ff;

   // stage 2: face selection and squares
   logic [MAG_W-1:0]          s2_num_in   [NUM_AXES];
   logic [MAG_W-1:0]          s2_den_in   [NUM_AXES];
   logic [NUM_AXES-1:0]       s2_faced_in;

   logic                      s2_vld_ff;
   logic signed [DIFF_W-1:0]  s2_dif_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]  s2_lod_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]  s2_hid_ff [NUM_AXES];
   logic [MAG_W-1:0]          s2_num_ff [NUM_AXES];
   logic [MAG_W-1:0]          s2_den_ff [NUM_AXES];
   logic [SQ_W-1:0]           s2_sq_ff  [NUM_AXES];
   logic [NUM_AXES-1:0]       s2_faced_ff;
   flag_type                  s2_flags_ff;

   // stage 3: cross products for the hit point test, length sum
   logic signed [MUL_W-1:0]   s3_pa_in [NUM_AXES][2];
   logic signed [MUL_W-1:0]   s3_pb_in [NUM_AXES][2];
   logic signed [MUL_W-1:0]   s3_pc_in [NUM_AXES][2];

   logic                      s3_vld_ff;
   logic [SUM_W-1:0]          s3_sum_ff;
   logic signed [MUL_W-1:0]   s3_pa_ff [NUM_AXES][2];
   logic signed [MUL_W-1:0]   s3_pb_ff [NUM_AXES][2];
   logic signed [MUL_W-1:0]   s3_pc_ff [NUM_AXES][2];
   logic [MAG_W-1:0]          s3_num_ff [NUM_AXES];
   logic [MAG_W-1:0]          s3_den_ff [NUM_AXES];
   logic [NUM_AXES-1:0]       s3_faced_ff;
   flag_type                  s3_flags_ff;

   // stage 4: face acceptance
   side_type                  s4_side_in;
   logic                      s4_vld_ff;
   logic [SUM_W-1:0]          s4_sum_ff;
   side_type                  s4_side_ff;

   // square root
   logic                      sq_vld;
   logic [ROOT_W-1:0]         sq_root;
   side_type                  sq_side;

   // distance products
   logic                      m1_vld_ff;
   logic [SQ_W-1:0]           m1_lo_ff [NUM_AXES];
   logic [MAG_W+ROOT_HI_W-1:0] m1_hi_ff [NUM_AXES];
   logic [NUM_AXES-1:0][MAG_W-1:0] m1_den_ff;
   logic [NUM_AXES-1:0]       m1_ok_ff;
   flag_type                  m1_flags_ff;

   logic                      m2_vld_ff;
   logic [NUM_AXES-1:0][PROD_W-1:0] m2_prod_ff;
   logic [NUM_AXES-1:0][MAG_W-1:0]  m2_den_ff;
   logic [NUM_AXES-1:0]       m2_ok_ff;
   flag_type                  m2_flags_ff;

   // dividers
   logic                      dv_vld;
   lane_res_type [NUM_AXES-1:0] dv_res;
   flag_type                  dv_flags;

   // minimum
   logic [VAL_W-1:0]          mn_val0;
   logic [VAL_W-1:0]          mn_val1;
   logic                      mn_vld_ff;
   logic                      mn_found_ff;
   logic [VAL_W-1:0]          mn_val_ff;
   logic                      mn_ok2_ff;
   logic [VAL_W-1:0]          mn_val2_ff;
   flag_type                  mn_flags_ff;

   // result register
   logic                      found;
   logic [VAL_W-1:0]          best;
   logic                      rsp_valid_ff;
   logic                      rsp_hit_in;
   logic                      rsp_inside_in;
   logic [DIST_W-1:0]         rsp_dist_in;
   logic                      rsp_sat_in;
   logic                      rsp_hit_ff;
   logic                      rsp_inside_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic                      rsp_sat_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------ stage 1
   assign st_c[0] = req_start_x;
   assign st_c[1] = req_start_y;
   assign st_c[2] = req_start_z;
   assign en_c[0] = req_end_x;
   assign en_c[1] = req_end_y;
   assign en_c[2] = req_end_z;
   assign lo_c[0] = req_box_min_x;
   assign lo_c[1] = req_box_min_y;
   assign lo_c[2] = req_box_min_z;
   assign hi_c[0] = req_box_max_x;
   assign hi_c[1] = req_box_max_y;
   assign hi_c[2] = req_box_max_z;

   always_comb begin
      s1_flags_in.zero_box = 1'b1;
      s1_flags_in.in_box   = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_dif_in[a] = DIFF_W'(en_c[a]) - DIFF_W'(st_c[a]);
         s1_lod_in[a] = DIFF_W'(lo_c[a]) - DIFF_W'(st_c[a]);
         s1_hid_in[a] = DIFF_W'(hi_c[a]) - DIFF_W'(st_c[a]);
         if (lo_c[a] != '0 || hi_c[a] != '0) begin
            s1_flags_in.zero_box = 1'b0;
         end
         if (st_c[a] < lo_c[a] || st_c[a] > hi_c[a]) begin
            s1_flags_in.in_box = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_flags_ff <= s1_flags_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            s1_dif_ff[a] <= s1_dif_in[a];
            s1_lod_ff[a] <= s1_lod_in[a];
            s1_hid_ff[a] <= s1_hid_in[a];
         end
      end
   end

   // ------------------------------------------------------------------ stage 2
   // only one face per axis can face the direction: the near min or the near max
   always_comb begin
      logic pos;
      logic neg;
      for (int a = 0; a < NUM_AXES; a++) begin
         neg = s1_dif_ff[a] < 0;
         pos = s1_dif_ff[a] > 0;
         s2_den_in[a]   = neg ? MAG_W'(-s1_dif_ff[a]) : MAG_W'(s1_dif_ff[a]);
         s2_num_in[a]   = pos ? MAG_W'(s1_lod_ff[a]) : MAG_W'(-s1_hid_ff[a]);
         s2_faced_in[a] = (pos && s1_lod_ff[a] > 0) || (neg && s1_hid_ff[a] < 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_flags_ff <= s1_flags_ff;
         s2_faced_ff <= s2_faced_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            s2_dif_ff[a] <= s1_dif_ff[a];
            s2_lod_ff[a] <= s1_lod_ff[a];
            s2_hid_ff[a] <= s1_hid_ff[a];
            s2_num_ff[a] <= s2_num_in[a];
            s2_den_ff[a] <= s2_den_in[a];
            s2_sq_ff[a]  <= s2_den_in[a] * s2_den_in[a];
         end
      end
   end

   // ------------------------------------------------------------------ stage 3
   always_comb begin
      int b;
      logic signed [DIFF_W-1:0] den_s;
      logic signed [DIFF_W-1:0] num_s;
      for (int a = 0; a < NUM_AXES; a++) begin
         den_s = $signed({1'b0, s2_den_ff[a]});
         num_s = $signed({1'b0, s2_num_ff[a]});
         for (int j = 0; j < 2; j++) begin
            b = a + 1 + j;
            if (b >= NUM_AXES) begin
               b = b - NUM_AXES;
            end
            s3_pa_in[a][j] = MUL_W'(s2_lod_ff[b]) * MUL_W'(den_s);
            s3_pb_in[a][j] = MUL_W'(num_s) * MUL_W'(s2_dif_ff[b]);
            s3_pc_in[a][j] = MUL_W'(s2_hid_ff[b]) * MUL_W'(den_s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sum_ff   <= SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1]) + SUM_W'(s2_sq_ff[2]);
         s3_flags_ff <= s2_flags_ff;
         s3_faced_ff <= s2_faced_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            s3_num_ff[a] <= s2_num_ff[a];
            s3_den_ff[a] <= s2_den_ff[a];
            for (int j = 0; j < 2; j++) begin
               s3_pa_ff[a][j] <= s3_pa_in[a][j];
               s3_pb_ff[a][j] <= s3_pb_in[a][j];
               s3_pc_ff[a][j] <= s3_pc_in[a][j];
            end
         end
      end
   end

   // ------------------------------------------------------------------ stage 4
   // hit point must lie within both other axes, bounds inclusive
   always_comb begin
      s4_side_in.flags = s3_flags_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         s4_side_in.num[a] = s3_num_ff[a];
         s4_side_in.den[a] = s3_den_ff[a];
         s4_side_in.ok[a]  = s3_faced_ff[a];
         for (int j = 0; j < 2; j++) begin
            if (s3_pa_ff[a][j] > s3_pb_ff[a][j] || s3_pb_ff[a][j] > s3_pc_ff[a][j]) begin
               s4_side_in.ok[a] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sum_ff  <= s3_sum_ff;
         s4_side_ff <= s4_side_in;
      end
   end

   // ------------------------------------------------------------------ length
   rbed_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s4_vld_ff),
      .in_sum    (s4_sum_ff),
      .in_side   (s4_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ------------------------------------------------------------ num * length
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= sq_vld;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_flags_ff <= sq_side.flags;
         m1_ok_ff    <= sq_side.ok;
         m1_den_ff   <= sq_side.den;
         for (int a = 0; a < NUM_AXES; a++) begin
            m1_lo_ff[a] <= sq_side.num[a] * sq_root[ROOT_LO_W-1:0];
            m1_hi_ff[a] <= sq_side.num[a] * sq_root[ROOT_W-1:ROOT_LO_W];
         end
         m2_flags_ff <= m1_flags_ff;
         m2_ok_ff    <= m1_ok_ff;
         m2_den_ff   <= m1_den_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            m2_prod_ff[a] <= PROD_W'(m1_lo_ff[a]) + {m1_hi_ff[a], {ROOT_LO_W{1'b0}}};
         end
      end
   end

   // ------------------------------------------------------------------ divide
   rbed_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m2_vld_ff),
      .in_prod   (m2_prod_ff),
      .in_den    (m2_den_ff),
      .in_ok     (m2_ok_ff),
      .in_flags  (m2_flags_ff),
      .out_valid (dv_vld),
      .out_res   (dv_res),
      .out_flags (dv_flags)
   );

   // ------------------------------------------------------------------ minimum
   assign mn_val0 = lane_val(dv_res[0]);
   assign mn_val1 = lane_val(dv_res[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mn_vld_ff <= 1'b0;
      end else if (adv) begin
         mn_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mn_found_ff <= dv_res[0].ok || dv_res[1].ok;
         if (dv_res[0].ok && (!dv_res[1].ok || mn_val0 <= mn_val1)) begin
            mn_val_ff <= mn_val0;
         end else begin
            mn_val_ff <= mn_val1;
         end
         mn_ok2_ff   <= dv_res[2].ok;
         mn_val2_ff  <= lane_val(dv_res[2]);
         mn_flags_ff <= dv_flags;
      end
   end

   // ------------------------------------------------------------------ result
   always_comb begin
      found = mn_found_ff || mn_ok2_ff;
      best  = (mn_found_ff && (!mn_ok2_ff || mn_val_ff <= mn_val2_ff)) ? mn_val_ff
                                                                       : mn_val2_ff;
      rsp_hit_in    = 1'b0;
      rsp_inside_in = 1'b0;
      rsp_dist_in   = '0;
      rsp_sat_in    = 1'b0;
      priority if (mn_flags_ff.zero_box) begin
         rsp_hit_in = 1'b0;
      end else if (mn_flags_ff.in_box) begin
         rsp_hit_in    = 1'b1;
         rsp_inside_in = 1'b1;
      end else if (found) begin
         rsp_hit_in  = 1'b1;
         rsp_sat_in  = best[VAL_W-1];
         rsp_dist_in = best[VAL_W-1] ? DIST_MAX : best[DIST_W-1:0];
      end else begin
         rsp_hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mn_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_inside_ff <= rsp_inside_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_start_inside   = rsp_inside_ff;
   assign rsp_entry_distance = rsp_dist_ff;
   assign rsp_saturated      = rsp_sat_ff;

   // ------------------------------------------------------------------ checks
   `RBED_ASSERT(a_stall_follows_output, req_stall == (rsp_valid && rsp_stall))
   `RBED_ASSERT_IMP(a_inside_is_zero, rsp_valid && rsp_start_inside,
      rsp_hit && rsp_entry_distance == '0 && !rsp_saturated)
   `RBED_ASSERT_IMP(a_sat_is_max, rsp_valid && rsp_saturated,
      rsp_hit && rsp_entry_distance == DIST_MAX)
   `RBED_ASSERT_IMP(a_miss_is_clear, rsp_valid && !rsp_hit,
      rsp_entry_distance == '0 && !rsp_start_inside)

endmodule

`default_nettype wire
